>>> rtl/alle_pkg.sv
package alle_pkg;

    // fixed field widths of the channels
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int OUT_W  = 6;
    localparam int STAT_W = 2;

    localparam int DEF_NODE_SLOTS = 64;
    localparam int DEF_DATA_BITS  = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic evaluate;
        logic wr1;
        logic wr2;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic op_fail;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/alle_if.sv
interface alle_in_if;
    import alle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  item_value;

    modport source (output valid, func, position, item_value, input ready);
    modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface alle_out_if;
    import alle_pkg::*;

    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  slot;
    logic [STAT_W-1:0] status;
    logic [OUT_W-1:0]  list_head;
    logic [OUT_W-1:0]  list_tail;
    logic [OUT_W-1:0]  count;

    modport source (output valid, slot, status, list_head, list_tail, count, input ready);
    modport sink   (input valid, slot, status, list_head, list_tail, count, output ready);
endinterface

>>> rtl/array_linked_list_engine.sv
// channel   dir  payload                                    accepted when
// i_in      in   func, position, item_value                 valid && ready
// o_out     out  slot, status, list_head, list_tail, count  valid && ready
//
// a successful operation goes from accept through lookup, two link writes
// and result load; a rejected one goes from lookup straight to result load
// the writes come as a pair because each link table has a single write port
// after reset a clearing pass over all NODE_SLOTS slots rebuilds the free
// chain, input ready stays low until it ends
// a result waiting on the output does not block the next accept; the
// operation after it holds in its last cycle until the output register frees
module array_linked_list_engine #(
    parameter int NODE_SLOTS = alle_pkg::DEF_NODE_SLOTS,
    parameter int DATA_BITS  = alle_pkg::DEF_DATA_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alle_in_if.sink    i_in,
    alle_out_if.source o_out
);
    import alle_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    alle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    alle_dp #(
        .NODE_SLOTS (NODE_SLOTS),
        .DATA_BITS  (DATA_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_func       (i_in.func),
        .i_position   (i_in.position),
        .i_item_value (i_in.item_value),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_slot       (o_out.slot),
        .o_status     (o_out.status),
        .o_list_head  (o_out.list_head),
        .o_list_tail  (o_out.list_tail),
        .o_count      (o_out.count)
    );

    assign i_in.ready = w_in_ready;

endmodule

>>> rtl/alle_ram.sv
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/alle_ctrl.sv
module alle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  alle_pkg::t_stat i_stat,
    output alle_pkg::t_cmd  o_cmd
);
    import alle_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_WR1  = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.evaluate = 1'b1;
                n_state = i_stat.op_fail ? S_FIN : S_WR1;
            end
            S_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = S_WR2;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // link updates always come as a write pair, wr1 then wr2
    a_wr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr1 |=> o_cmd.wr2)
        else $error("write pair broken");

endmodule

>>> rtl/alle_dp.sv
module alle_dp #(
    parameter int NODE_SLOTS = alle_pkg::DEF_NODE_SLOTS,
    parameter int DATA_BITS  = alle_pkg::DEF_DATA_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  alle_pkg::t_cmd                    i_cmd,
    output alle_pkg::t_stat                   o_stat,
    input  logic                              i_func,
    input  logic [alle_pkg::POS_W-1:0]        i_position,
    input  logic signed [alle_pkg::VAL_W-1:0] i_item_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [alle_pkg::OUT_W-1:0]        o_slot,
    output logic [alle_pkg::STAT_W-1:0]       o_status,
    output logic [alle_pkg::OUT_W-1:0]        o_list_head,
    output logic [alle_pkg::OUT_W-1:0]        o_list_tail,
    output logic [alle_pkg::OUT_W-1:0]        o_count
);
    import alle_pkg::*;

    localparam int IDX_W = $clog2(NODE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_SLOTS - 1);

    // operation registers
    logic                 r_func;
    logic [POS_W-1:0]     r_pos;
    logic [IDX_W-1:0]     r_pidx;
    logic                 r_inrange;
    logic [DATA_BITS-1:0] r_value;
    logic [IDX_W-1:0]     r_nx;
    logic [IDX_W-1:0]     r_pv;
    logic [IDX_W-1:0]     r_into;
    logic [STAT_W-1:0]    r_status;
    logic [OUT_W-1:0]     r_slot;

    // list state
    logic [IDX_W-1:0]     r_free;
    logic [IDX_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_tail;
    logic [IDX_W-1:0]     r_clr;

    // result register
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_o_slot;
    logic [STAT_W-1:0]    r_o_status;
    logic [OUT_W-1:0]     r_o_head;
    logic [OUT_W-1:0]     r_o_tail;
    logic [OUT_W-1:0]     r_o_count;

    logic [IDX_W-1:0]     w_in_idx;
    logic [IDX_W-1:0]     w_next_rd;
    logic [IDX_W-1:0]     w_prev_rd;
    logic                 w_used_rd;
    logic [IDX_W-1:0]     w_next_raddr;
    logic                 w_bad;
    logic                 w_full;
    logic                 w_ins;
    logic [IDX_W-1:0]     w_clr_next;

    logic                 w_next_we;
    logic [IDX_W-1:0]     w_next_waddr;
    logic [IDX_W-1:0]     w_next_wdata;
    logic                 w_prev_we;
    logic [IDX_W-1:0]     w_prev_waddr;
    logic [IDX_W-1:0]     w_prev_wdata;
    logic                 w_used_we;
    logic [IDX_W-1:0]     w_used_waddr;
    logic                 w_used_wdata;
    logic                 w_data_we;

    assign w_in_idx = IDX_W'(i_position);
    assign w_ins    = (r_func == FUNC_INSERT);

    // lookup of node_next[free_first] rides the evaluate cycle
    assign w_next_raddr = i_cmd.accept ? w_in_idx : r_free;

    assign w_bad  = !r_inrange || !w_used_rd || (!w_ins && (r_pidx == '0));
    assign w_full = w_ins && (r_free == '0);

    assign o_stat.op_fail  = w_bad || w_full;
    assign o_stat.clr_last = (r_clr == LAST_IDX);
    assign o_stat.out_free = !r_out_valid || i_ready;

    assign w_clr_next = ((r_clr == LAST_IDX) || (r_clr == '0)) ? '0 : r_clr + 1'b1;

    always_comb begin
        w_next_we    = 1'b0;
        w_next_waddr = r_pidx;
        w_next_wdata = '0;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_pidx;
        w_prev_wdata = '0;
        w_used_we    = 1'b0;
        w_used_waddr = r_pidx;
        w_used_wdata = 1'b0;
        w_data_we    = 1'b0;
        if (i_cmd.clr_wr) begin
            w_next_we    = 1'b1;
            w_next_waddr = r_clr;
            w_next_wdata = w_clr_next;
            w_prev_we    = 1'b1;
            w_prev_waddr = r_clr;
            w_used_we    = 1'b1;
            w_used_waddr = r_clr;
            w_used_wdata = (r_clr == '0);
        end else if (i_cmd.wr1) begin
            w_next_we = 1'b1;
            w_prev_we = 1'b1;
            w_used_we = 1'b1;
            if (w_ins) begin
                // pos -> into, prev of old successor -> into
                w_next_waddr = r_pidx;
                w_next_wdata = r_into;
                w_prev_waddr = r_nx;
                w_prev_wdata = r_into;
                w_used_waddr = r_into;
                w_used_wdata = 1'b1;
                w_data_we    = 1'b1;
            end else begin
                // bridge neighbors around the deleted node
                w_next_waddr = r_pv;
                w_next_wdata = r_nx;
                w_prev_waddr = r_nx;
                w_prev_wdata = r_pv;
                w_used_waddr = r_pidx;
                w_used_wdata = 1'b0;
            end
        end else if (i_cmd.wr2) begin
            w_next_we = 1'b1;
            w_prev_we = 1'b1;
            if (w_ins) begin
                w_next_waddr = r_into;
                w_next_wdata = r_nx;
                w_prev_waddr = r_into;
                w_prev_wdata = r_pidx;
            end else begin
                // freed slot goes on the front of the free chain
                w_next_waddr = r_pidx;
                w_next_wdata = r_free;
                w_prev_waddr = r_pidx;
                w_prev_wdata = '0;
            end
        end
    end

    alle_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_next_raddr),
        .o_rdata (w_next_rd)
    );

    alle_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_waddr),
        .i_wdata (w_prev_wdata),
        .i_raddr (w_in_idx),
        .o_rdata (w_prev_rd)
    );

    alle_ram #(.WIDTH(1), .DEPTH(NODE_SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (w_in_idx),
        .o_rdata (w_used_rd)
    );

    alle_ram #(.WIDTH(DATA_BITS), .DEPTH(NODE_SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (r_into),
        .i_wdata (r_value),
        .i_raddr ('0),
        .o_rdata ()
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_free      <= IDX_W'(1);
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr && (r_clr != LAST_IDX)) begin
                r_clr <= r_clr + 1'b1;
            end
            // sentinel links mirrored for head and tail
            if (w_next_we && (w_next_waddr == '0)) begin
                r_head <= w_next_wdata;
            end
            if (w_prev_we && (w_prev_waddr == '0)) begin
                r_tail <= w_prev_wdata;
            end
            if (i_cmd.wr1 && w_ins) begin
                r_free <= w_next_rd;
            end
            if (i_cmd.wr2) begin
                if (w_ins) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                    r_free  <= r_pidx;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_pos     <= i_position;
            r_pidx    <= w_in_idx;
            r_inrange <= (32'(i_position) < 32'(NODE_SLOTS));
            r_value   <= DATA_BITS'($unsigned(i_item_value));
        end
        if (i_cmd.evaluate) begin
            r_nx   <= w_next_rd;
            r_pv   <= w_prev_rd;
            r_into <= r_free;
            if (w_bad) begin
                r_status <= ST_BAD;
                r_slot   <= r_pos;
            end else if (w_full) begin
                r_status <= ST_FULL;
                r_slot   <= r_pos;
            end else begin
                r_status <= ST_OK;
                r_slot   <= w_ins ? OUT_W'(r_free) : r_pos;
            end
        end
        if (i_cmd.finish) begin
            r_o_slot   <= r_slot;
            r_o_status <= r_status;
            r_o_head   <= OUT_W'(r_head);
            r_o_tail   <= OUT_W'(r_tail);
            r_o_count  <= OUT_W'(r_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_slot      = r_o_slot;
    assign o_status    = r_o_status;
    assign o_list_head = r_o_head;
    assign o_list_tail = r_o_tail;
    assign o_count     = r_o_count;

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> ((r_count == '0) == (r_head == '0)))
        else $error("head disagrees with count");

    a_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> ((r_count == '0) == (r_tail == '0)))
        else $error("tail disagrees with count");

    a_no_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr1 && w_ins) |-> (r_into != '0))
        else $error("insert took sentinel slot");

endmodule
